/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CHK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_CHK(name, prop, msg)
`define ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

/* rtl/gcbs_pkg.sv */
// ----------------------------------------------------------------------------
// Grid cell bucket store package
// Shared defaults, field widths and operation codes.
// ----------------------------------------------------------------------------
package gcbs_pkg;

  localparam int unsigned CELL_ROWS_DEF      = 8;
  localparam int unsigned CELL_COLS_DEF      = 8;
  localparam int unsigned SLOTS_PER_CELL_DEF = 8;

  // row is at most 7 and columns at most 64, so the raw cell index fits 9 bits
  localparam int unsigned CELL_CALC_W = 9;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned ID_W        = 32;

  typedef enum logic [2:0] {
    FUNC_INSERT    = 3'd0,
    FUNC_FIND      = 3'd1,
    FUNC_OVERWRITE = 3'd2,
    FUNC_REMOVE    = 3'd3,
    FUNC_READ      = 3'd4
  } func_e;

endpackage

/* rtl/gcbs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gcbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/grid_cell_bucket_store_unit.sv */
// ----------------------------------------------------------------------------
// Grid cell bucket store unit
// Uniform grid of cells, each with a fixed number of object slots.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* carries one operation per item (insert, find id,
//   overwrite slot, remove last, read last); master channel m_axis_* returns
//   exactly one result item per operation, in order.
//   Per item, from accept to result valid, the unit steps through ST_FILL (fill
//   count read), ST_DECIDE and ST_OUT (output register load); remove and read
//   add ST_DATA for the slot read if the cell is not empty, and find adds
//   ST_SCAN, which scans k (1 to SLOTS_PER_CELL) slots of a non-empty cell.
//   The slot RAM read port scans one slot per cycle. A new item is accepted no
//   earlier than the cycle after the result is loaded, so items do not overlap.
//   After reset the fill count RAM is swept to zero, one cell per cycle, over
//   all CELL_ROWS * CELL_COLS cells; s_axis_tready stays low meanwhile.
//   A result waits in the output register while m_axis_tready is low; the
//   next item is still accepted and worked on, and its result waits until
//   the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_cell_bucket_store_unit #(
  parameter int unsigned CELL_ROWS      = gcbs_pkg::CELL_ROWS_DEF,
  parameter int unsigned CELL_COLS      = gcbs_pkg::CELL_COLS_DEF,
  parameter int unsigned SLOTS_PER_CELL = gcbs_pkg::SLOTS_PER_CELL_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_row[2:0], cell_col[5:3], slot_position[14:6], obj_id[46:15],
  // latitude[78:47], longitude[110:79], zero[111]
  input  logic [111:0] s_axis_tdata,
  // func[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found_cell[5:0], found_slot[14:6], result_id[46:15], result_lat[78:47],
  // result_lon[110:79], cell_fill[114:111], store_empty[115], zero[119:116]
  output logic [119:0] m_axis_tdata,
  // ok[0]
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned NUM_CELLS = CELL_ROWS * CELL_COLS;
  localparam int unsigned NUM_SLOTS = NUM_CELLS * SLOTS_PER_CELL;
  localparam int unsigned CELL_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned FILL_W    = $clog2(SLOTS_PER_CELL + 1);
  localparam int unsigned TOT_W     = $clog2(NUM_SLOTS + 1);
  localparam int unsigned CALC_W    = gcbs_pkg::CELL_CALC_W;
  localparam int unsigned ID_W      = gcbs_pkg::ID_W;
  localparam int unsigned CRD_W     = gcbs_pkg::COORD_W;
  localparam int unsigned DATA_W    = ID_W + 2 * CRD_W;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_FILL   = 7'b0000100,
    ST_DECIDE = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_DATA   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  state_e                  state_q, state_d;
  logic [CELL_AW-1:0]      clr_cnt_q, clr_cnt_d;
  gcbs_pkg::func_e         func_q, func_d;
  logic [CALC_W-1:0]       cell_q, cell_d;
  logic                    cell_ok_q, cell_ok_d;
  logic [8:0]              pos_q, pos_d;
  logic [ID_W-1:0]         id_q, id_d;
  logic signed [CRD_W-1:0] lat_q, lat_d;
  logic signed [CRD_W-1:0] lon_q, lon_d;
  logic [SLOT_AW-1:0]      base_q, base_d;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic [FILL_W-1:0]       idx_q, idx_d;
  logic                    ok_q, ok_d;
  logic [SLOT_AW-1:0]      slot_q, slot_d;
  logic [ID_W-1:0]         rid_q, rid_d;
  logic signed [CRD_W-1:0] rlat_q, rlat_d;
  logic signed [CRD_W-1:0] rlon_q, rlon_d;
  logic [TOT_W-1:0]        total_q, total_d;
  logic                    m_valid_q, m_valid_d;
  logic [119:0]            m_tdata_q, m_tdata_d;
  logic                    m_ok_q, m_ok_d;

  logic [2:0]              in_row, in_col;
  logic [CELL_AW-1:0]      cell_addr;
  logic [FILL_W-1:0]       fill_cur;
  logic [SLOT_AW-1:0]      scan_slot;
  logic [SLOT_AW-1:0]      last_slot;
  logic [SLOT_AW+8:0]      slot_ext;
  logic [FILL_W+3:0]       fill_ext;

  logic                    fill_wr_en, fill_rd_en;
  logic [CELL_AW-1:0]      fill_wr_addr;
  logic [FILL_W-1:0]       fill_wr_data, fill_rd_data;
  logic                    data_wr_en, data_rd_en;
  logic [SLOT_AW-1:0]      data_wr_addr, data_rd_addr;
  logic [DATA_W-1:0]       data_rd_data;

  gcbs_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_CELLS)
  ) u_fill_ram (
    .clk_i     (clk_i),
    .wr_en_i   (fill_wr_en),
    .wr_addr_i (fill_wr_addr),
    .wr_data_i (fill_wr_data),
    .rd_en_i   (fill_rd_en),
    .rd_addr_i (cell_addr),
    .rd_data_o (fill_rd_data)
  );

  gcbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (data_wr_en),
    .wr_addr_i (data_wr_addr),
    .wr_data_i ({lon_q, lat_q, id_q}),
    .rd_en_i   (data_rd_en),
    .rd_addr_i (data_rd_addr),
    .rd_data_o (data_rd_data)
  );

  assign in_row    = s_axis_tdata[2:0];
  assign in_col    = s_axis_tdata[5:3];
  assign cell_addr = CELL_AW'(cell_q);
  assign fill_cur  = cell_ok_q ? fill_rd_data : '0;
  assign scan_slot = base_q + SLOT_AW'(idx_q);
  assign last_slot = base_q + SLOT_AW'(fill_cur - 1'b1);
  assign slot_ext  = {9'd0, slot_q};
  assign fill_ext  = {4'd0, fill_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_ok_q;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    func_d       = func_q;
    cell_d       = cell_q;
    cell_ok_d    = cell_ok_q;
    pos_d        = pos_q;
    id_d         = id_q;
    lat_d        = lat_q;
    lon_d        = lon_q;
    base_d       = base_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    ok_d         = ok_q;
    slot_d       = slot_q;
    rid_d        = rid_q;
    rlat_d       = rlat_q;
    rlon_d       = rlon_q;
    total_d      = total_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_tdata_d    = m_tdata_q;
    m_ok_d       = m_ok_q;
    fill_wr_en   = 1'b0;
    fill_wr_addr = cell_addr;
    fill_wr_data = '0;
    fill_rd_en   = 1'b0;
    data_wr_en   = 1'b0;
    data_wr_addr = slot_q;
    data_rd_en   = 1'b0;
    data_rd_addr = scan_slot;

    case (state_q)
      ST_CLEAR: begin
        fill_wr_en   = 1'b1;
        fill_wr_addr = clr_cnt_q;
        if (clr_cnt_q == CELL_AW'(NUM_CELLS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_d    = gcbs_pkg::func_e'(s_axis_tuser);
          cell_d    = CALC_W'(32'(in_row) * CELL_COLS + 32'(in_col));
          cell_ok_d = (32'(in_row) < CELL_ROWS) && (32'(in_col) < CELL_COLS);
          pos_d     = s_axis_tdata[14:6];
          id_d      = s_axis_tdata[46:15];
          lat_d     = s_axis_tdata[78:47];
          lon_d     = s_axis_tdata[110:79];
          ok_d      = 1'b0;
          slot_d    = '0;
          rid_d     = '0;
          rlat_d    = '0;
          rlon_d    = '0;
          state_d   = ST_FILL;
        end
      end
      ST_FILL: begin
        fill_rd_en = 1'b1;
        base_d     = SLOT_AW'(32'(cell_addr) * SLOTS_PER_CELL);
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        fill_d  = fill_cur;
        state_d = ST_OUT;
        if (func_q == gcbs_pkg::FUNC_OVERWRITE) begin
          if (32'(pos_q) < NUM_SLOTS) begin
            data_wr_en   = 1'b1;
            data_wr_addr = SLOT_AW'(pos_q);
            slot_d       = SLOT_AW'(pos_q);
            ok_d         = 1'b1;
          end
        end else if (cell_ok_q) begin
          case (func_q)
            gcbs_pkg::FUNC_INSERT: begin
              if (32'(fill_cur) < SLOTS_PER_CELL) begin
                data_wr_en   = 1'b1;
                data_wr_addr = base_q + SLOT_AW'(fill_cur);
                slot_d       = base_q + SLOT_AW'(fill_cur);
                fill_wr_en   = 1'b1;
                fill_wr_data = fill_cur + 1'b1;
                fill_d       = fill_cur + 1'b1;
                total_d      = total_q + 1'b1;
                ok_d         = 1'b1;
              end
            end
            gcbs_pkg::FUNC_FIND: begin
              if (fill_cur != '0) begin
                data_rd_en   = 1'b1;
                data_rd_addr = base_q;
                idx_d        = '0;
                state_d      = ST_SCAN;
              end
            end
            gcbs_pkg::FUNC_REMOVE, gcbs_pkg::FUNC_READ: begin
              if (fill_cur != '0) begin
                data_rd_en   = 1'b1;
                data_rd_addr = last_slot;
                slot_d       = last_slot;
                ok_d         = 1'b1;
                state_d      = ST_DATA;
                if (func_q == gcbs_pkg::FUNC_REMOVE) begin
                  fill_wr_en   = 1'b1;
                  fill_wr_data = fill_cur - 1'b1;
                  fill_d       = fill_cur - 1'b1;
                  if (total_q != '0) begin
                    total_d = total_q - 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (data_rd_data[ID_W-1:0] == id_q) begin
          ok_d    = 1'b1;
          slot_d  = scan_slot;
          state_d = ST_OUT;
        end else if (idx_q + 1'b1 == fill_q) begin
          state_d = ST_OUT;
        end else begin
          idx_d        = idx_q + 1'b1;
          data_rd_en   = 1'b1;
          data_rd_addr = scan_slot + 1'b1;
        end
      end
      ST_DATA: begin
        rid_d   = data_rd_data[ID_W-1:0];
        rlat_d  = data_rd_data[ID_W+CRD_W-1:ID_W];
        rlon_d  = data_rd_data[DATA_W-1:ID_W+CRD_W];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_ok_d    = ok_q;
          m_tdata_d = {4'd0, (total_q == '0), fill_ext[3:0], rlon_q, rlat_q, rid_q,
                       slot_ext[8:0], cell_q[5:0]};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      total_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      total_q   <= total_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    cell_q    <= cell_d;
    cell_ok_q <= cell_ok_d;
    pos_q     <= pos_d;
    id_q      <= id_d;
    lat_q     <= lat_d;
    lon_q     <= lon_d;
    base_q    <= base_d;
    fill_q    <= fill_d;
    idx_q     <= idx_d;
    ok_q      <= ok_d;
    slot_q    <= slot_d;
    rid_q     <= rid_d;
    rlat_q    <= rlat_d;
    rlon_q    <= rlon_d;
    m_tdata_q <= m_tdata_d;
    m_ok_q    <= m_ok_d;
  end

  `ASSERT_CHK(a_total_bound, 32'(total_q) <= NUM_SLOTS, "total count above slot count")
  `ASSERT_CHK(a_scan_in_fill, (state_q != ST_SCAN) || (idx_q < fill_q), "scan past fill")
  `ASSERT_CHK(a_fill_bound, !fill_wr_en || (32'(fill_wr_data) <= SLOTS_PER_CELL),
              "fill overflow")
  `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
               "ready after accept")
  `ASSERT_NEXT(a_insert_count,
               (state_q == ST_DECIDE) && (func_q == gcbs_pkg::FUNC_INSERT) && cell_ok_q &&
               (32'(fill_cur) < SLOTS_PER_CELL),
               total_q == $past(total_q) + 1'b1, "insert lost count")

endmodule
